// File: design/pressure_sensor_poll_sequencer_defines.svh
`ifndef PRESSURE_SENSOR_POLL_SEQUENCER_DEFINES_SVH
`define PRESSURE_SENSOR_POLL_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/psps_pkg.sv
package psps_pkg;

    localparam int DIAG_INTERVAL = 5;
    localparam logic [2:0] DIAG_LAST = 3'((DIAG_INTERVAL - 1) & 7);

    localparam logic [7:0] SENSOR_ID = 8'hBD;
    localparam logic [15:0] PERIOD_RESET = 16'd100;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_PERIOD_TICKS = 1'b0;

    typedef enum logic [1:0] {
        CMD_NONE       = 2'd0,
        CMD_READ_ID    = 2'd1,
        CMD_WRITE_CTRL = 2'd2,
        CMD_READ_PRESS = 2'd3
    } t_bus_cmd;

    typedef struct packed {
        logic       bus_done;
        logic [7:0] rx_byte0;
        logic [7:0] rx_byte1;
        logic [7:0] rx_byte2;
    } t_item;

    typedef struct packed {
        t_bus_cmd    bus_command;
        logic [11:0] pressure_value;
        logic        pressure_valid;
        logic        error_flag;
        logic        ready_flag;
    } t_result;

endpackage

// File: design/pressure_sensor_poll_sequencer.sv
// Pressure sensor poll sequencer: one input word per bus tick (done flag and
// up to three received bytes), one result word per input word (bus command,
// held pressure, capture pulse, sticky error, init-done flag).
// Input channel: i_valid / o_stall; output channel: o_valid / i_stall. A word
// moves at a rising edge with valid high and stall low.
// Data path: an input register, then the sequencer step logic feeding the
// result register. Throughput is one word per cycle when not stalled; the
// step logic is a flag decode plus one 16-bit increment and compare.
// When the receiver stalls, the result register holds its word and one more
// word waits in the input register; o_stall rises only when both are full.
// Reset (i_rst_n low, synchronous) empties both registers, clears the
// sequencer state and loads period_ticks with 100. The APB port writes
// period_ticks at byte address 0; pready is always high.
module pressure_sensor_poll_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_bus_done,
    input  logic [7:0]                          i_rx_byte0,
    input  logic [7:0]                          i_rx_byte1,
    input  logic [7:0]                          i_rx_byte2,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_bus_command,
    output logic [11:0]                         o_pressure_value,
    output logic                                o_pressure_valid,
    output logic                                o_error_flag,
    output logic                                o_ready_flag,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [psps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [psps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    `include "pressure_sensor_poll_sequencer_defines.svh"

    logic               r_in_valid;
    psps_pkg::t_item    r_in;
    logic               r_out_valid;
    psps_pkg::t_result  r_out;
    psps_pkg::t_result  w_result;
    logic [15:0]        w_period_ticks;
    logic               w_adv;

    psps_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_period_ticks (w_period_ticks)
    );

    psps_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_adv),
        .i_item         (r_in),
        .i_period_ticks (w_period_ticks),
        .o_result       (w_result)
    );

    assign w_adv   = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in.bus_done <= i_bus_done;
            r_in.rx_byte0 <= i_rx_byte0;
            r_in.rx_byte1 <= i_rx_byte1;
            r_in.rx_byte2 <= i_rx_byte2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_bus_command    = r_out.bus_command;
    assign o_pressure_value = r_out.pressure_value;
    assign o_pressure_valid = r_out.pressure_valid;
    assign o_error_flag     = r_out.error_flag;
    assign o_ready_flag     = r_out.ready_flag;

    `PSPS_ASSERT_NOW(a_capture_only_when_running, i_clk, i_rst_n, o_valid && o_pressure_valid, o_ready_flag && !o_error_flag, "pressure captured outside normal operation")
    `PSPS_ASSERT_NOW(a_ctrl_write_in_init, i_clk, i_rst_n, o_valid && (o_bus_command == psps_pkg::CMD_WRITE_CTRL), !o_ready_flag, "control write issued after init")
    `PSPS_ASSERT_NOW(a_burst_when_running, i_clk, i_rst_n, o_valid && (o_bus_command == psps_pkg::CMD_READ_PRESS), o_ready_flag && !o_error_flag, "burst read issued outside normal operation")
    `PSPS_ASSERT_NEXT(a_full_pipe_stalls, i_clk, i_rst_n, r_in_valid && r_out_valid && i_stall, r_out_valid, "result word dropped while stalled")

endmodule

// File: design/psps_cfg.sv
module psps_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [psps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [psps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [15:0]                         o_period_ticks
);

    logic [15:0] r_period_ticks;
    logic        w_sel_period;

    assign pready       = 1'b1;
    assign w_sel_period = (paddr[2] == psps_pkg::REG_PERIOD_TICKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_ticks <= psps_pkg::PERIOD_RESET;
        end else if (psel && penable && pwrite && w_sel_period) begin
            r_period_ticks <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_period) begin
            prdata = {16'd0, r_period_ticks};
        end
    end

    assign o_period_ticks = r_period_ticks;

endmodule

// File: design/psps_seq.sv
module psps_seq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  psps_pkg::t_item         i_item,
    input  logic [15:0]             i_period_ticks,
    output psps_pkg::t_result       o_result
);

    logic        r_started, r_id_checked, r_configured, r_error_state;
    logic        r_reading, r_got_sample, r_done_pending;
    logic [2:0]  r_diag_count;
    logic [15:0] r_tick_count;
    logic [11:0] r_pressure_hold;
    logic [7:0]  r_rx0, r_rx1, r_rx2;

    logic        n_started, n_id_checked, n_configured, n_error_state;
    logic        n_reading, n_got_sample, n_done_pending;
    logic [2:0]  n_diag_count;
    logic [15:0] n_tick_count;
    logic [11:0] n_pressure_hold;
    logic [7:0]  n_rx0, n_rx1, n_rx2;

    psps_pkg::t_bus_cmd w_cmd;
    logic               w_valid;

    always_comb begin
        n_started       = r_started;
        n_id_checked    = r_id_checked;
        n_configured    = r_configured;
        n_error_state   = r_error_state;
        n_reading       = r_reading;
        n_got_sample    = r_got_sample;
        n_done_pending  = r_done_pending;
        n_diag_count    = r_diag_count;
        n_tick_count    = r_tick_count;
        n_pressure_hold = r_pressure_hold;
        n_rx0           = r_rx0;
        n_rx1           = r_rx1;
        n_rx2           = r_rx2;
        w_cmd           = psps_pkg::CMD_NONE;
        w_valid         = 1'b0;

        if (i_item.bus_done) begin
            n_done_pending = 1'b1;
            n_rx0          = i_item.rx_byte0;
            n_rx1          = i_item.rx_byte1;
            n_rx2          = i_item.rx_byte2;
        end

        if (!r_configured) begin
            if (n_id_checked && !n_configured && n_done_pending) begin
                n_done_pending = 1'b0;
                n_configured   = 1'b1;
                n_diag_count   = '0;
            end
            if (n_started && !n_id_checked && n_done_pending) begin
                n_done_pending = 1'b0;
                if (n_rx0 == psps_pkg::SENSOR_ID) begin
                    n_error_state = 1'b0;
                    n_id_checked  = 1'b1;
                    w_cmd         = psps_pkg::CMD_WRITE_CTRL;
                end else begin
                    n_error_state = 1'b1;
                    n_configured  = 1'b1;
                end
            end
            if (!n_started) begin
                w_cmd         = psps_pkg::CMD_READ_ID;
                n_started     = 1'b1;
                n_error_state = 1'b0;
            end
        end else if (!r_error_state) begin
            if (r_reading) begin
                n_tick_count = r_tick_count + 16'd1;
                if (r_diag_count == psps_pkg::DIAG_LAST) begin
                    if (n_done_pending) begin
                        n_done_pending = 1'b0;
                        if (n_rx0 != psps_pkg::SENSOR_ID) begin
                            n_error_state = 1'b1;
                        end
                        n_reading    = 1'b0;
                        n_diag_count = '0;
                    end
                    if (n_tick_count >= i_period_ticks) begin
                        n_error_state = 1'b1;
                    end
                end else begin
                    if (n_done_pending) begin
                        n_done_pending  = 1'b0;
                        n_pressure_hold = {n_rx2, n_rx1[7:4]};
                        w_valid         = 1'b1;
                        n_got_sample    = 1'b1;
                    end
                    if (n_tick_count >= i_period_ticks) begin
                        n_diag_count = r_diag_count + 3'd1;
                        n_reading    = 1'b0;
                        if (!n_got_sample) begin
                            n_error_state = 1'b1;
                        end
                    end
                end
            end else begin
                n_got_sample = 1'b0;
                if (r_diag_count == '0) begin
                    n_tick_count = r_tick_count + 16'd1;
                end else begin
                    n_tick_count = 16'd1;
                end
                w_cmd     = (r_diag_count == psps_pkg::DIAG_LAST) ?
                            psps_pkg::CMD_READ_ID : psps_pkg::CMD_READ_PRESS;
                n_reading = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started       <= 1'b0;
            r_id_checked    <= 1'b0;
            r_configured    <= 1'b0;
            r_error_state   <= 1'b0;
            r_reading       <= 1'b0;
            r_got_sample    <= 1'b0;
            r_done_pending  <= 1'b0;
            r_diag_count    <= '0;
            r_tick_count    <= '0;
            r_pressure_hold <= '0;
        end else if (i_en) begin
            r_started       <= n_started;
            r_id_checked    <= n_id_checked;
            r_configured    <= n_configured;
            r_error_state   <= n_error_state;
            r_reading       <= n_reading;
            r_got_sample    <= n_got_sample;
            r_done_pending  <= n_done_pending;
            r_diag_count    <= n_diag_count;
            r_tick_count    <= n_tick_count;
            r_pressure_hold <= n_pressure_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx0 <= n_rx0;
            r_rx1 <= n_rx1;
            r_rx2 <= n_rx2;
        end
    end

    always_comb begin
        o_result.bus_command    = w_cmd;
        o_result.pressure_value = n_pressure_hold;
        o_result.pressure_valid = w_valid;
        o_result.error_flag     = n_error_state;
        o_result.ready_flag     = n_configured;
    end

endmodule

// File: verif/pressure_sensor_poll_sequencer_tb.sv
module pressure_sensor_poll_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psps_pkg::*;

    localparam logic [APB_ADDR_W-1:0] PERIOD_ADDR = APB_ADDR_W'(4 * int'(REG_PERIOD_TICKS));
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int RANDOM_WORDS = 1500;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_bus_done = 1'b0;
    logic [7:0]            i_rx_byte0 = '0;
    logic [7:0]            i_rx_byte1 = '0;
    logic [7:0]            i_rx_byte2 = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [1:0]            o_bus_command;
    logic [11:0]           o_pressure_value;
    logic                  o_pressure_valid;
    logic                  o_error_flag;
    logic                  o_ready_flag;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pressure_sensor_poll_sequencer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_bus_done       (i_bus_done),
        .i_rx_byte0       (i_rx_byte0),
        .i_rx_byte1       (i_rx_byte1),
        .i_rx_byte2       (i_rx_byte2),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_bus_command    (o_bus_command),
        .o_pressure_value (o_pressure_value),
        .o_pressure_valid (o_pressure_valid),
        .o_error_flag     (o_error_flag),
        .o_ready_flag     (o_ready_flag),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // sequencer state as the block should hold it
    logic        seq_started = 1'b0;
    logic        seq_id_ok = 1'b0;
    logic        seq_ready = 1'b0;
    logic        seq_err = 1'b0;
    logic        seq_reading = 1'b0;
    logic        seq_sampled = 1'b0;
    logic [2:0]  seq_diag = '0;
    logic [15:0] seq_ticks = '0;
    logic [11:0] seq_press = '0;
    logic        seq_done_held = 1'b0;
    logic [7:0]  seq_rx [3] = '{8'h00, 8'h00, 8'h00};
    logic [15:0] cfg_period = PERIOD_RESET;

    t_result tick_results_q [$];

    int    mismatch_count = 0;
    int    words_sent = 0;
    int    results_checked = 0;
    int    captures_seen = 0;
    int    in_stall_cycles = 0;
    bit    steady_flow = 1'b0;
    bit    hold_off_req = 1'b0;
    string error_kind = "none";

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_result step_sequencer(input t_item w);
        t_result     r;
        t_bus_cmd    cmd;
        logic        pv;
        logic [23:0] word;
        cmd = CMD_NONE;
        pv  = 1'b0;
        if (w.bus_done) begin
            seq_done_held = 1'b1;
            seq_rx[0] = w.rx_byte0;
            seq_rx[1] = w.rx_byte1;
            seq_rx[2] = w.rx_byte2;
        end
        if (!seq_ready) begin
            if (seq_id_ok && seq_done_held) begin
                seq_done_held = 1'b0;
                seq_ready = 1'b1;
                seq_diag = '0;
            end
            if (seq_started && !seq_id_ok && seq_done_held) begin
                seq_done_held = 1'b0;
                if (seq_rx[0] == SENSOR_ID) begin
                    seq_err = 1'b0;
                    seq_id_ok = 1'b1;
                    cmd = CMD_WRITE_CTRL;
                end else begin
                    seq_err = 1'b1;
                    seq_ready = 1'b1;
                end
            end
            if (!seq_started) begin
                cmd = CMD_READ_ID;
                seq_started = 1'b1;
                seq_err = 1'b0;
            end
        end else if (!seq_err) begin
            if (seq_reading) begin
                seq_ticks = seq_ticks + 16'd1;
                if (seq_diag == DIAG_LAST) begin
                    if (seq_done_held) begin
                        seq_done_held = 1'b0;
                        if (seq_rx[0] != SENSOR_ID) seq_err = 1'b1;
                        seq_reading = 1'b0;
                        seq_diag = '0;
                    end
                    if (seq_ticks >= cfg_period) seq_err = 1'b1;
                end else begin
                    if (seq_done_held) begin
                        seq_done_held = 1'b0;
                        word = {seq_rx[2], seq_rx[1], seq_rx[0]};
                        seq_press = word[23:12];
                        pv = 1'b1;
                        seq_sampled = 1'b1;
                    end
                    if (seq_ticks >= cfg_period) begin
                        seq_diag = seq_diag + 3'd1;
                        seq_reading = 1'b0;
                        if (!seq_sampled) seq_err = 1'b1;
                    end
                end
            end else begin
                seq_sampled = 1'b0;
                if (seq_diag == '0) seq_ticks = seq_ticks + 16'd1;
                else seq_ticks = 16'd1;
                cmd = (seq_diag == DIAG_LAST) ? CMD_READ_ID : CMD_READ_PRESS;
                seq_reading = 1'b1;
            end
        end
        r.bus_command    = cmd;
        r.pressure_value = seq_press;
        r.pressure_valid = pv;
        r.error_flag     = seq_err;
        r.ready_flag     = seq_ready;
        return r;
    endfunction

    // Well-formed bus traffic: replies land inside their period, ID replies carry the ID.
    function automatic t_item next_word();
        t_item w;
        logic  id_slot;
        w.bus_done = ($urandom_range(99) < 25);
        w.rx_byte0 = 8'($urandom);
        w.rx_byte1 = 8'($urandom);
        w.rx_byte2 = 8'($urandom);
        id_slot = !seq_ready || (seq_diag == DIAG_LAST);
        if (seq_ready && !seq_err && seq_reading && !seq_done_held) begin
            if (id_slot) begin
                if (int'(seq_ticks) + 2 >= int'(cfg_period)) w.bus_done = 1'b1;
            end else if (!seq_sampled && int'(seq_ticks) + 1 >= int'(cfg_period)) begin
                w.bus_done = 1'b1;
            end
        end
        // a held pressure reply would be taken as the ID, so overwrite it
        if (id_slot && seq_done_held) w.bus_done = 1'b1;
        if (id_slot) w.rx_byte0 = SENSOR_ID;
        return w;
    endfunction

    function automatic t_item quiet_word();
        return t_item'{1'b0, 8'($urandom), 8'($urandom), 8'($urandom)};
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
    endtask

    task automatic send_word(input t_item w);
        int gap;
        gap = 0;
        while (!steady_flow && $urandom_range(99) < 36) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_bus_done <= w.bus_done;
        i_rx_byte0 <= w.rx_byte0;
        i_rx_byte1 <= w.rx_byte1;
        i_rx_byte2 <= w.rx_byte2;
        do @(posedge i_clk); while (o_stall);
        tick_results_q.push_back(step_sequencer(w));
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (tick_results_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PERIOD_ADDR;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_period_reg();
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(cfg_period))
            log_mismatch($sformatf("period register read %h, expected %h", rd, cfg_period));
    endtask

    task automatic set_period(input logic [15:0] ticks);
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b1, APB_DATA_W'(ticks), rd);
        cfg_period = ticks;
        check_period_reg();
    endtask

    // Short periods (< 3 ticks) cannot pass an ID re-check, so they stop ahead of one;
    // other settings run on until no re-check is pending.
    task automatic run_period_chunk(input logic [15:0] ticks, input int len);
        int n;
        n = 0;
        wait_results_drained();
        set_period(ticks);
        if (ticks < 16'd3) begin
            while (n < len && seq_diag != DIAG_LAST) begin
                send_word(next_word());
                n++;
            end
        end else begin
            while (n < len || seq_diag == DIAG_LAST) begin
                send_word(next_word());
                n++;
            end
        end
    endtask

    initial begin
        forever begin
            int hold_left;
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (steady_flow) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 36);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && i_valid && o_stall) in_stall_cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            got.bus_command    = t_bus_cmd'(o_bus_command);
            got.pressure_value = o_pressure_value;
            got.pressure_valid = o_pressure_valid;
            got.error_flag     = o_error_flag;
            got.ready_flag     = o_ready_flag;
            results_checked++;
            if (tick_results_q.size() == 0) begin
                log_mismatch($sformatf("unexpected word cmd=%0d press=%h pv=%b err=%b rdy=%b",
                    o_bus_command, o_pressure_value, o_pressure_valid, o_error_flag,
                    o_ready_flag));
            end else begin
                want = tick_results_q.pop_front();
                if (want.pressure_valid) captures_seen++;
                if (got.bus_command !== want.bus_command
                        || got.pressure_value !== want.pressure_value
                        || got.pressure_valid !== want.pressure_valid
                        || got.error_flag !== want.error_flag
                        || got.ready_flag !== want.ready_flag) begin
                    log_mismatch($sformatf(
                        "word %0d exp cmd=%0d press=%h pv=%b err=%b rdy=%b, got cmd=%0d press=%h pv=%b err=%b rdy=%b",
                        results_checked, want.bus_command, want.pressure_value,
                        want.pressure_valid, want.error_flag, want.ready_flag,
                        o_bus_command, o_pressure_value, o_pressure_valid, o_error_flag,
                        o_ready_flag));
                end
            end
        end
    end

    task automatic test_register_access();
        check_period_reg();
        set_period(16'd6);
    endtask

    // ID reply arrives early, on the very first tick, and is held until the ID read waits
    task automatic test_init_handshake();
        send_word(t_item'{1'b1, SENSOR_ID, 8'h00, 8'hFF});
        send_word(t_item'{1'b0, 8'hFF, 8'hFF, 8'hFF});
        send_word(t_item'{1'b0, 8'h00, 8'h00, 8'h00});
        send_word(t_item'{1'b1, 8'h3C, 8'hA5, 8'h5A});
    endtask

    task automatic test_pressure_capture();
        send_word(t_item'{1'b0, 8'hFF, 8'hFF, 8'hFF});
        send_word(t_item'{1'b1, 8'h00, 8'h00, 8'h00});
        send_word(t_item'{1'b1, 8'hFF, 8'hFF, 8'hFF});
        send_word(t_item'{1'b1, 8'h56, 8'h34, 8'h12});
        send_word(t_item'{1'b0, 8'hAA, 8'h55, 8'hAA});
        send_word(t_item'{1'b1, 8'h0F, 8'hF0, 8'hA5});
        // completion on the period-start tick, consumed on the next one
        send_word(t_item'{1'b1, 8'h11, 8'h22, 8'h33});
        send_word(t_item'{1'b0, 8'h00, 8'h00, 8'h00});
    endtask

    task automatic test_period_extremes();
        run_period_chunk(16'd0, 6);
        run_period_chunk(16'hFFFF, 6);
    endtask

    task automatic test_random_traffic();
        int          budget;
        int          len;
        int          roll;
        int          chunk_idx;
        int          sent_at_start;
        logic [15:0] ticks;
        budget = 0;
        chunk_idx = 0;
        while (budget < RANDOM_WORDS) begin
            roll = $urandom_range(99);
            if (roll < 65) ticks = 16'($urandom_range(3, 10));
            else if (roll < 85) ticks = 16'($urandom_range(11, 60));
            else if (roll < 95) ticks = 16'($urandom_range(0, 2));
            else ticks = 16'($urandom_range(1000, 65535));
            len = (ticks > 16'd60) ? $urandom_range(10, 30) : $urandom_range(40, 160);
            if (chunk_idx == 2) begin
                ticks = 16'($urandom_range(3, 10));
                len = 300;
            end
            sent_at_start = words_sent;
            steady_flow = (chunk_idx == 2);
            run_period_chunk(ticks, len);
            budget += words_sent - sent_at_start;
            chunk_idx++;
        end
        wait_results_drained();
        steady_flow = 1'b0;
    endtask

    task automatic test_output_backpressure();
        int n;
        n = 0;
        set_period(16'd8);
        steady_flow = 1'b1;
        hold_off_req = 1'b1;
        while (n < 40 || seq_diag == DIAG_LAST) begin
            send_word(next_word());
            n++;
        end
        steady_flow = 1'b0;
    endtask

    // The error is sticky and reset happens once, so exactly one error source runs here.
    task automatic test_sticky_error();
        int kind;
        wait_results_drained();
        set_period(16'd5);
        kind = $urandom_range(2);
        if (kind == 0) begin
            error_kind = "a pressure read timeout";
            while (!(seq_diag != DIAG_LAST && !seq_reading)) send_word(next_word());
            while (!seq_err) send_word(quiet_word());
        end else begin
            // no completion may be left pending when the re-check starts
            while (!(seq_diag == DIAG_LAST && !seq_reading))
                send_word((seq_reading && seq_sampled) ? quiet_word() : next_word());
            send_word(quiet_word());
            if (kind == 1) begin
                error_kind = "a wrong ID on re-check";
                send_word(t_item'{1'b1, SENSOR_ID ^ 8'($urandom_range(1, 255)),
                                  8'($urandom), 8'($urandom)});
            end else begin
                error_kind = "an ID re-check answered on the timeout tick";
                while (int'(seq_ticks) + 1 < int'(cfg_period)) send_word(quiet_word());
                send_word(t_item'{1'b1, SENSOR_ID, 8'($urandom), 8'($urandom)});
            end
        end
        repeat (20) send_word(t_item'(25'($urandom)));
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_register_access();
        test_init_handshake();
        test_pressure_capture();
        test_period_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_sticky_error();

        wait_results_drained();
        repeat (6) @(posedge i_clk);
        if (tick_results_q.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", tick_results_q.size()));

        $display("Covered %0d bus ticks, %0d result words, %0d pressure captures, %0d input stall cycles",
                 words_sent, results_checked, captures_seen, in_stall_cycles);
        $display("Period settings from 0 to 65535 ticks; run closed with %s", error_kind);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/psps_pkg.sv
design/psps_cfg.sv
design/psps_seq.sv
design/pressure_sensor_poll_sequencer.sv
verif/pressure_sensor_poll_sequencer_tb.sv
